FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the EEPROM sequencer.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/core/iems_pkg.sv
// Types, codes and reset constants of the I2C EEPROM sequencer.
// No dependencies; imported by the sequencer top level.
package iems_pkg;

    localparam int IEMS_PAGE_DEPTH = 16;

    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;
    localparam logic [4:0] PAGE_LENGTH_RESET    = 5'd5;
    localparam logic [7:0] READ_REGISTER_RESET  = 8'h77;

    // Item modes
    localparam logic [2:0] MODE_TICK       = 3'd0;
    localparam logic [2:0] MODE_BYTE_WRITE = 3'd1;
    localparam logic [2:0] MODE_PAGE_WRITE = 3'd2;
    localparam logic [2:0] MODE_READ       = 3'd3;
    localparam logic [2:0] MODE_LOAD       = 3'd4;

    // Configuration register indexes
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_PAGE_LENGTH    = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'd0,
        ST_START    = 5'd1,
        ST_DEVW     = 5'd2,
        ST_ACK_DEVW = 5'd3,
        ST_ADDR     = 5'd4,
        ST_ACK_ADDR = 5'd5,
        ST_DATA     = 5'd6,
        ST_ACK_DATA = 5'd7,
        ST_RSTART   = 5'd8,
        ST_DEVR     = 5'd9,
        ST_ACK_DEVR = 5'd10,
        ST_READ     = 5'd11,
        ST_MNACK    = 5'd12,
        ST_STOP     = 5'd13
    } seq_state_t;

    // Codes match the start modes
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_PAGE = 2'd2,
        KIND_READ = 2'd3
    } xfer_kind_t;

endpackage

FILE: rtl/core/iems_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module iems_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/i2c_eeprom_master_sequencer.sv
// Top level of the bit-level I2C EEPROM master sequencer.
// Depends on iems_pkg, iems_ram and assert_macros.svh.
//
// Each accepted item is one bus phase tick and yields exactly one registered
// result: the SCL level and SDA drive for that phase, the busy and done
// flags, the read byte and the sticky NACK flag. A transaction starts on an
// idle tick whose mode is byte write, page write or random read; every
// condition and bit slot takes four ticks. Items are taken in every cycle
// except while a result waits on a stalled output, since one output register
// separates the two sides; item_stall rises only when that register is full
// and stalled. Unless stalled, the rate is one item per clock, set by the
// single registered pass from the state registers to the result register.
// Page bytes live in a small RAM written by load items (mode 4) at any time;
// the byte of a page write is fetched when the preceding acknowledge slot
// ends and is used from the next tick on, with a bypass for a load to the
// same slot on that tick. Configuration writes are always accepted (cfg_ready
// is tied high) and must only occur while no transaction is running.
module i2c_eeprom_master_sequencer
    import iems_pkg::*;
#(
    parameter int PAGE_DEPTH = IEMS_PAGE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    // item channel
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [2:0] mode,
    input  logic [7:0] word_address,
    input  logic [7:0] write_data,
    input  logic [3:0] page_index,
    input  logic       sda_in,
    // result channel
    output logic       result_valid,
    input  logic       result_stall,
    output logic       scl_level,
    output logic       sda_release,
    output logic       busy_res,
    output logic       done_res,
    output logic       read_valid,
    output logic [7:0] rx_data,
    output logic       nack_seen
);

`include "assert_macros.svh"

    localparam int AW = (PAGE_DEPTH > 1) ? $clog2(PAGE_DEPTH) : 1;

    // configuration
    logic [6:0] dev_addr_reg;
    logic [4:0] page_len_reg;

    // sequencer state
    seq_state_t state_reg, state_next;
    xfer_kind_t kind_reg, kind_next;
    logic [1:0] phase_reg, phase_next;
    logic [3:0] bit_reg, bit_next;
    logic [4:0] byte_reg, byte_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] laddr_reg, laddr_next;
    logic [7:0] ldata_reg, ldata_next;
    logic [7:0] rd_reg, rd_next;
    logic       nack_reg, nack_next;

    // page fetch in flight and same-slot load bypass
    logic       pend_reg, pend_next;
    logic       byp_valid_reg, byp_valid_next;
    logic [7:0] byp_data_reg;

    // result register
    logic       res_valid_reg;
    logic       scl_reg, rel_reg, busy_reg, done_reg, rvalid_reg, nackout_reg;
    logic [7:0] rdout_reg;

    // working values
    logic          accept;
    logic          start_go;
    logic          load_hit;
    seq_state_t    st;
    logic [1:0]    ph;
    logic [3:0]    bit_inc;
    logic [4:0]    byte_inc;
    logic          page_last;
    logic [7:0]    shift_eff;
    logic          scl_c, rel_c, done_c, rvalid_c;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;

    assign cfg_ready    = 1'b1;
    assign item_stall   = res_valid_reg && result_stall;
    assign accept       = item_valid && !item_stall;

    assign load_hit  = (mode == MODE_LOAD) && (page_index < PAGE_DEPTH);
    assign ram_we    = accept && load_hit;
    assign ram_waddr = AW'(page_index);

    iems_ram #(
        .WIDTH (8),
        .DEPTH (PAGE_DEPTH)
    ) u_page_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (write_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= DEVICE_ADDRESS_RESET;
            page_len_reg <= PAGE_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: dev_addr_reg <= cfg_data[6:0];
                CFG_PAGE_LENGTH:    page_len_reg <= cfg_data[4:0];
                default:            dev_addr_reg <= dev_addr_reg;
            endcase
        end
    end

    // next state and line levels for one tick
    always_comb
    begin
        start_go = (state_reg == ST_IDLE) && (mode == MODE_BYTE_WRITE ||
                   mode == MODE_PAGE_WRITE || mode == MODE_READ);

        // a start resets the counters before this tick is played out
        st        = start_go ? ST_START : state_reg;
        ph        = start_go ? 2'd0 : phase_reg;
        bit_next  = start_go ? 4'd0 : bit_reg;
        byte_next = start_go ? 5'd0 : byte_reg;
        kind_next = start_go ? xfer_kind_t'(mode[1:0]) : kind_reg;
        laddr_next = start_go ? word_address : laddr_reg;
        ldata_next = start_go ? write_data : ldata_reg;
        nack_next  = start_go ? 1'b0 : nack_reg;

        // a fetched page byte takes the place of the shift register
        if (pend_reg)
        begin
            shift_eff = byp_valid_reg ? byp_data_reg : ram_rdata;
        end
        else
        begin
            shift_eff = shift_reg;
        end

        state_next     = st;
        phase_next     = ph;
        shift_next     = shift_eff;
        rd_next        = rd_reg;
        pend_next      = 1'b0;
        byp_valid_next = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        bit_inc        = bit_next + 4'd1;
        byte_inc       = byte_next + 5'd1;
        page_last      = (page_len_reg == 5'd0) ||
                         ((page_len_reg > PAGE_DEPTH) ? (byte_inc >= PAGE_DEPTH)
                                                      : (byte_inc >= page_len_reg));

        scl_c    = 1'b1;
        rel_c    = 1'b1;
        done_c   = 1'b0;
        rvalid_c = 1'b0;

        // line levels and sampling
        case (st)
            ST_IDLE:
            begin
                scl_c = 1'b1;
            end
            ST_START, ST_RSTART:
            begin
                scl_c = (ph == 2'd1) || (ph == 2'd2);
                rel_c = (ph <= 2'd1);
            end
            ST_STOP:
            begin
                scl_c = (ph != 2'd0);
                rel_c = (ph >= 2'd2);
                if (ph == 2'd3)
                begin
                    done_c   = 1'b1;
                    rvalid_c = (kind_next == KIND_READ);
                end
            end
            ST_DEVW, ST_ADDR, ST_DATA, ST_DEVR:
            begin
                scl_c = (ph == 2'd1) || (ph == 2'd2);
                rel_c = shift_eff[7];
            end
            ST_ACK_DEVW, ST_ACK_ADDR, ST_ACK_DATA, ST_ACK_DEVR:
            begin
                scl_c = (ph == 2'd1) || (ph == 2'd2);
                if (ph == 2'd2 && sda_in)
                begin
                    nack_next = 1'b1;
                end
            end
            ST_READ:
            begin
                scl_c = (ph == 2'd1) || (ph == 2'd2);
                if (ph == 2'd2)
                begin
                    rd_next = {rd_reg[6:0], sda_in};
                end
            end
            default:
            begin
                scl_c = (ph == 2'd1) || (ph == 2'd2);
            end
        endcase

        // advance the phase; the last phase closes the slot
        if (st != ST_IDLE)
        begin
            if (ph != 2'd3)
            begin
                phase_next = ph + 2'd1;
            end
            else
            begin
                phase_next = 2'd0;
                case (st)
                    ST_START:
                    begin
                        state_next = ST_DEVW;
                        shift_next = {dev_addr_reg, 1'b0};
                        bit_next   = 4'd0;
                    end
                    ST_DEVW, ST_ADDR, ST_DATA, ST_DEVR:
                    begin
                        shift_next = {shift_eff[6:0], 1'b0};
                        bit_next   = bit_inc;
                        if (bit_inc >= 4'd8)
                        begin
                            bit_next = 4'd0;
                            case (st)
                                ST_DEVW: state_next = ST_ACK_DEVW;
                                ST_ADDR: state_next = ST_ACK_ADDR;
                                ST_DATA: state_next = ST_ACK_DATA;
                                default: state_next = ST_ACK_DEVR;
                            endcase
                        end
                    end
                    ST_ACK_DEVW:
                    begin
                        state_next = ST_ADDR;
                        shift_next = laddr_next;
                        bit_next   = 4'd0;
                    end
                    ST_ACK_ADDR:
                    begin
                        case (kind_next)
                            KIND_READ:
                            begin
                                state_next = ST_RSTART;
                            end
                            KIND_BYTE:
                            begin
                                state_next = ST_DATA;
                                shift_next = ldata_next;
                                bit_next   = 4'd0;
                            end
                            default:
                            begin
                                // fetch the first page byte
                                state_next = ST_DATA;
                                bit_next   = 4'd0;
                                byte_next  = 5'd0;
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                pend_next  = 1'b1;
                                byp_valid_next = load_hit && (ram_waddr == ram_raddr);
                            end
                        endcase
                    end
                    ST_ACK_DATA:
                    begin
                        if (kind_next == KIND_PAGE)
                        begin
                            byte_next = byte_inc;
                            if (page_last)
                            begin
                                state_next = ST_STOP;
                            end
                            else
                            begin
                                state_next = ST_DATA;
                                bit_next   = 4'd0;
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(byte_inc);
                                pend_next  = 1'b1;
                                byp_valid_next = load_hit && (ram_waddr == ram_raddr);
                            end
                        end
                        else
                        begin
                            state_next = ST_STOP;
                        end
                    end
                    ST_RSTART:
                    begin
                        state_next = ST_DEVR;
                        shift_next = {dev_addr_reg, 1'b1};
                        bit_next   = 4'd0;
                    end
                    ST_ACK_DEVR:
                    begin
                        // clear the read register as the read byte begins
                        state_next = ST_READ;
                        bit_next   = 4'd0;
                        rd_next    = 8'd0;
                    end
                    ST_READ:
                    begin
                        bit_next = bit_inc;
                        if (bit_inc >= 4'd8)
                        begin
                            state_next = ST_MNACK;
                            bit_next   = 4'd0;
                        end
                    end
                    ST_MNACK:
                    begin
                        state_next = ST_STOP;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
        end
    end

    // sequencer registers: advance on every accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_NONE;
            phase_reg     <= 2'd0;
            bit_reg       <= 4'd0;
            byte_reg      <= 5'd0;
            shift_reg     <= 8'd0;
            laddr_reg     <= 8'd0;
            ldata_reg     <= 8'd0;
            rd_reg        <= READ_REGISTER_RESET;
            nack_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
            byte_reg      <= byte_next;
            shift_reg     <= shift_next;
            laddr_reg     <= laddr_next;
            ldata_reg     <= ldata_next;
            rd_reg        <= rd_next;
            nack_reg      <= nack_next;
            pend_reg      <= pend_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    // hold the load data in case it hits the slot being fetched
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byp_data_reg <= write_data;
        end
    end

    // result register: drop the valid once the transfer is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scl_reg     <= scl_c;
            rel_reg     <= rel_c;
            busy_reg    <= (st != ST_IDLE);
            done_reg    <= done_c;
            rvalid_reg  <= rvalid_c;
            rdout_reg   <= rd_next;
            nackout_reg <= nack_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign scl_level    = scl_reg;
    assign sda_release  = rel_reg;
    assign busy_res     = busy_reg;
    assign done_res     = done_reg;
    assign read_valid   = rvalid_reg;
    assign rx_data      = rdout_reg;
    assign nack_seen    = nackout_reg;

    `ASSERT_IMPL(a_pend_in_data, pend_reg, state_reg == ST_DATA, "fetch pending outside data")
    `ASSERT_IMPL(a_idle_phase, state_reg == ST_IDLE, phase_reg == 2'd0, "idle with phase set")
    `ASSERT_IMPL(a_rvalid_done, result_valid && read_valid, done_res && busy_res, "stray rvalid")
    `ASSERT_NEXT(a_start, accept && start_go, state_reg == ST_START && phase_reg == 2'd1, "no start")

endmodule
